@@ rtl/core/bpsci_pkg.sv @@
// Shared types, codes and sizing constants for the byte-port SCSI command interface.
`default_nettype none

package bpsci_pkg;

    // Storage sizes.
    localparam int CDB_DEPTH = 16;
    localparam int BUF_DEPTH = 65536;
    localparam int CDB_IDX_W = $clog2(CDB_DEPTH);
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(BUF_DEPTH - 1);

    // Each buffer entry carries a generation tag next to its data byte.
    localparam int EPOCH_W = 8;
    localparam int RAM_W   = EPOCH_W + 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // Stream widths.
    localparam int IN_DATA_W = 24;
    localparam int IN_USER_W = 5;
    localparam int OUT_W     = 48;

    // Function codes.
    localparam logic [2:0] FUNC_BUS_RD = 3'd0;
    localparam logic [2:0] FUNC_BUS_WR = 3'd1;
    localparam logic [2:0] FUNC_BUF_WR = 3'd2;
    localparam logic [2:0] FUNC_BUF_RD = 3'd3;
    localparam logic [2:0] FUNC_CDB_RD = 3'd4;
    localparam logic [2:0] FUNC_DONE   = 3'd5;

    // Bus register indexes.
    localparam logic [1:0] REG_CMD   = 2'd0;
    localparam logic [1:0] REG_DATA  = 2'd1;
    localparam logic [1:0] REG_IDENT = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DIR    = 3'd1,
        PH_CDBLEN = 3'd2,
        PH_LENLO  = 3'd3,
        PH_LENHI  = 3'd4,
        PH_CDB    = 3'd5,
        PH_READY  = 3'd6
    } phase_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [RAM_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic [7:0]         rd_local;
        logic               use_mem;
        logic [EPOCH_W-1:0] epoch;
        logic               ready;
        logic               busy;
        logic [7:0]         target;
        logic               to_dev;
        logic [7:0]         cdb_len;
        logic [15:0]        buf_len;
        logic               err;
    } result_t;

    // True when a 16-bit position lies inside the data buffer.
    function automatic logic in_buf(input logic [15:0] pos);
        return {1'b0, pos} < 17'(BUF_DEPTH);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bpsci_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bpsci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bpsci_cmd.sv @@
// Command state, CDB store, buffer pointers and buffer RAM request generation.
`default_nettype none

module bpsci_cmd (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [2:0]         func,
    input  wire logic [1:0]         reg_index,
    input  wire logic [7:0]         data_byte,
    input  wire logic [15:0]        backend_index,
    output bpsci_pkg::mem_req_t     mem_req,
    output bpsci_pkg::result_t      res,
    output logic                    sweep_busy
);

    bpsci_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  target_reg, target_next;
    logic [7:0]  dir_reg, dir_next;
    logic [7:0]  cdb_len_reg, cdb_len_next;
    logic [7:0]  cdb_fill_reg, cdb_fill_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] pos_reg, pos_next;
    logic        busy_reg, busy_next;
    logic [7:0]  ident_reg, ident_next;
    logic [bpsci_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic        sweep_reg, sweep_next;
    logic [bpsci_pkg::ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [7:0]  cdb_mem_reg [bpsci_pkg::CDB_DEPTH];

    logic        to_dev;
    logic [7:0]  fill_inc;
    logic [15:0] pos_inc;
    logic [15:0] len_full;
    logic        hdr_wr;
    logic        make_ready;
    logic        data_rd;
    logic        data_wr_ok;
    logic        clear_cmd;
    logic        buf_ok;
    logic        cdb_ok;
    logic        cdb_room;
    logic        cdb_wr;
    logic        err;
    logic        ready;
    logic        use_mem;
    logic [7:0]  rd;

    assign to_dev     = (dir_reg == 8'd1);
    assign fill_inc   = cdb_fill_reg + 8'd1;
    assign pos_inc    = pos_reg + 16'd1;
    assign len_full   = {data_byte, remaining_reg[7:0]};
    assign hdr_wr     = accept && (func == bpsci_pkg::FUNC_BUS_WR)
                        && (reg_index == bpsci_pkg::REG_CMD);
    assign make_ready = hdr_wr
                        && (((phase_reg == bpsci_pkg::PH_LENHI) && (cdb_len_reg == 8'd0))
                         || ((phase_reg == bpsci_pkg::PH_CDB) && (fill_inc == cdb_len_reg)));
    assign data_rd    = accept && (func == bpsci_pkg::FUNC_BUS_RD)
                        && (reg_index == bpsci_pkg::REG_DATA) && (remaining_reg != 16'd0);
    assign data_wr_ok = (phase_reg == bpsci_pkg::PH_READY) && (pos_reg < remaining_reg)
                        && bpsci_pkg::in_buf(pos_reg);
    // The guest draining the last byte, or completion of a write toward the device,
    // drops the command.
    assign clear_cmd  = (data_rd && (remaining_reg == 16'd1))
                        || (accept && (func == bpsci_pkg::FUNC_DONE) && to_dev);
    assign buf_ok     = (backend_index < remaining_reg) && bpsci_pkg::in_buf(backend_index);
    assign cdb_ok     = (backend_index < {8'd0, cdb_len_reg})
                        && (backend_index < 16'(bpsci_pkg::CDB_DEPTH));
    assign cdb_room   = cdb_fill_reg < 8'(bpsci_pkg::CDB_DEPTH);
    assign cdb_wr     = hdr_wr && (phase_reg == bpsci_pkg::PH_CDB) && cdb_room;
    assign sweep_busy = sweep_reg;

    // Header sequencer.
    always_comb begin
        phase_next = phase_reg;
        if (clear_cmd) begin
            phase_next = bpsci_pkg::PH_IDLE;
        end else if (hdr_wr) begin
            unique case (phase_reg) inside
                bpsci_pkg::PH_IDLE:   phase_next = bpsci_pkg::PH_DIR;
                bpsci_pkg::PH_DIR:    phase_next = bpsci_pkg::PH_CDBLEN;
                bpsci_pkg::PH_CDBLEN: phase_next = bpsci_pkg::PH_LENLO;
                bpsci_pkg::PH_LENLO:  phase_next = bpsci_pkg::PH_LENHI;
                bpsci_pkg::PH_LENHI,
                bpsci_pkg::PH_CDB:    phase_next = make_ready ? bpsci_pkg::PH_READY
                                                              : bpsci_pkg::PH_CDB;
                default:              phase_next = phase_reg;
            endcase
        end
    end

    // Register updates, result fields and buffer RAM requests.
    always_comb begin
        target_next     = target_reg;
        dir_next        = dir_reg;
        cdb_len_next    = cdb_len_reg;
        cdb_fill_next   = cdb_fill_reg;
        remaining_next  = remaining_reg;
        pos_next        = pos_reg;
        busy_next       = busy_reg;
        ident_next      = ident_reg;
        epoch_next      = epoch_reg;
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        err             = 1'b0;
        ready           = 1'b0;
        use_mem         = 1'b0;
        rd              = 8'd0;
        mem_req.we      = 1'b0;
        mem_req.re      = 1'b0;
        mem_req.addr    = pos_reg[bpsci_pkg::ADDR_W-1:0];
        mem_req.wdata   = {epoch_reg, data_byte};

        if (accept) begin
            unique case (func)
                bpsci_pkg::FUNC_BUS_RD: begin
                    unique case (reg_index)
                        bpsci_pkg::REG_CMD:   rd = {7'd0, busy_reg};
                        bpsci_pkg::REG_DATA: begin
                            if (remaining_reg != 16'd0) begin
                                if (bpsci_pkg::in_buf(pos_reg)) begin
                                    mem_req.re = 1'b1;
                                    use_mem    = 1'b1;
                                end else begin
                                    err = 1'b1;
                                end
                                pos_next       = pos_inc;
                                remaining_next = remaining_reg - 16'd1;
                            end
                        end
                        bpsci_pkg::REG_IDENT: rd = ident_reg;
                        default:              err = 1'b1;
                    endcase
                end
                bpsci_pkg::FUNC_BUS_WR: begin
                    unique case (reg_index)
                        bpsci_pkg::REG_CMD: begin
                            unique case (phase_reg)
                                bpsci_pkg::PH_IDLE:   target_next = data_byte;
                                bpsci_pkg::PH_DIR:    dir_next = data_byte;
                                bpsci_pkg::PH_CDBLEN: begin
                                    cdb_len_next = data_byte;
                                    err = data_byte > 8'(bpsci_pkg::CDB_DEPTH);
                                end
                                bpsci_pkg::PH_LENLO:  remaining_next = {8'd0, data_byte};
                                bpsci_pkg::PH_LENHI: begin
                                    remaining_next = len_full;
                                    err = {1'b0, len_full} > 17'(bpsci_pkg::BUF_DEPTH);
                                end
                                bpsci_pkg::PH_CDB: begin
                                    // Bytes past the store are counted but dropped.
                                    err           = !cdb_room;
                                    cdb_fill_next = fill_inc;
                                end
                                default: err = 1'b1;
                            endcase
                        end
                        bpsci_pkg::REG_DATA: begin
                            if (data_wr_ok) begin
                                mem_req.we = 1'b1;
                                pos_next   = pos_inc;
                                if (pos_inc == remaining_reg) begin
                                    busy_next = 1'b1;
                                    ready     = 1'b1;
                                end
                            end else begin
                                err = 1'b1;
                            end
                        end
                        bpsci_pkg::REG_IDENT: ident_next = data_byte;
                        default:              err = 1'b1;
                    endcase
                end
                bpsci_pkg::FUNC_BUF_WR: begin
                    mem_req.addr = backend_index[bpsci_pkg::ADDR_W-1:0];
                    mem_req.we   = buf_ok;
                    err          = !buf_ok;
                end
                bpsci_pkg::FUNC_BUF_RD: begin
                    mem_req.addr = backend_index[bpsci_pkg::ADDR_W-1:0];
                    mem_req.re   = buf_ok;
                    use_mem      = buf_ok;
                    err          = !buf_ok;
                end
                bpsci_pkg::FUNC_CDB_RD: begin
                    if (cdb_ok) begin
                        rd = cdb_mem_reg[backend_index[bpsci_pkg::CDB_IDX_W-1:0]];
                    end else begin
                        err = 1'b1;
                    end
                end
                bpsci_pkg::FUNC_DONE: begin
                    busy_next = 1'b0;
                    if (to_dev) begin
                        remaining_next = 16'd0;
                    end
                end
                default: err = 1'b1;
            endcase
        end

        if (make_ready && !to_dev) begin
            busy_next = 1'b1;
            ready     = 1'b1;
        end

        if (clear_cmd) begin
            cdb_len_next  = 8'd0;
            cdb_fill_next = 8'd0;
            pos_next      = 16'd0;
            target_next   = 8'd0;
        end

        // A new command starts a new buffer generation, so older bytes read as zero.
        // When the tag space runs out, every tag is swept back to zero.
        if (sweep_reg) begin
            mem_req.we      = 1'b1;
            mem_req.addr    = sweep_addr_reg;
            mem_req.wdata   = '0;
            sweep_addr_next = sweep_addr_reg + bpsci_pkg::ADDR_W'(1);
            if (sweep_addr_reg == bpsci_pkg::ADDR_LAST) begin
                sweep_next = 1'b0;
            end
        end else if (make_ready) begin
            if (epoch_reg == bpsci_pkg::EPOCH_LAST) begin
                epoch_next      = bpsci_pkg::EPOCH_FIRST;
                sweep_next      = 1'b1;
                sweep_addr_next = '0;
            end else begin
                epoch_next = epoch_reg + bpsci_pkg::EPOCH_W'(1);
            end
        end

        res.rd_local = rd;
        res.use_mem  = use_mem;
        res.epoch    = epoch_reg;
        res.ready    = ready;
        res.busy     = busy_next;
        res.target   = target_next;
        res.to_dev   = (dir_next == 8'd1);
        res.cdb_len  = cdb_len_next;
        res.buf_len  = remaining_next;
        res.err      = err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= bpsci_pkg::PH_IDLE;
            target_reg     <= 8'd0;
            dir_reg        <= 8'd0;
            cdb_len_reg    <= 8'd0;
            cdb_fill_reg   <= 8'd0;
            remaining_reg  <= 16'd0;
            pos_reg        <= 16'd0;
            busy_reg       <= 1'b0;
            ident_reg      <= 8'd0;
            epoch_reg      <= bpsci_pkg::EPOCH_FIRST;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            target_reg     <= target_next;
            dir_reg        <= dir_next;
            cdb_len_reg    <= cdb_len_next;
            cdb_fill_reg   <= cdb_fill_next;
            remaining_reg  <= remaining_next;
            pos_reg        <= pos_next;
            busy_reg       <= busy_next;
            ident_reg      <= ident_next;
            epoch_reg      <= epoch_next;
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_cmd) begin
            for (int i = 0; i < bpsci_pkg::CDB_DEPTH; i++) begin
                cdb_mem_reg[i] <= 8'd0;
            end
        end else if (cdb_wr) begin
            cdb_mem_reg[cdb_fill_reg[bpsci_pkg::CDB_IDX_W-1:0]] <= data_byte;
        end
    end

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sweep_reg && accept))
        else $error("beat accepted during tag sweep");

    a_epoch_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != '0)
        else $error("generation tag reached the swept value");

    a_one_ram_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.we && mem_req.re))
        else $error("buffer RAM read and write in the same cycle");

    a_ready_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        make_ready |=> (phase_reg == bpsci_pkg::PH_READY))
        else $error("command became ready but phase did not follow");

endmodule

`default_nettype wire

@@ rtl/core/bpsci_resp.sv @@
// Result stage that merges buffer RAM read data, followed by the output register.
`default_nettype none

module bpsci_resp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  wire bpsci_pkg::result_t           res_in,
    input  wire logic [bpsci_pkg::RAM_W-1:0]  ram_rdata,
    output logic                              load_ready,
    input  wire logic                         m_tready,
    output logic                              m_tvalid,
    output logic [bpsci_pkg::OUT_W-1:0]       m_tdata
);

    bpsci_pkg::result_t s2_reg;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic [bpsci_pkg::OUT_W-1:0] out_data_reg;
    logic [bpsci_pkg::OUT_W-1:0] out_data_next;
    logic move;
    logic tag_hit;
    logic [7:0] read_data;

    assign move       = s2_valid_reg && (!out_valid_reg || m_tready);
    assign load_ready = !s2_valid_reg || move;
    // A byte counts only if it was written during the current command's generation.
    assign tag_hit    = ram_rdata[bpsci_pkg::RAM_W-1:8] == s2_reg.epoch;
    assign read_data  = s2_reg.use_mem ? (tag_hit ? ram_rdata[7:0] : 8'd0) : s2_reg.rd_local;

    always_comb begin
        out_data_next = {4'd0, s2_reg.err, s2_reg.buf_len, s2_reg.cdb_len, s2_reg.to_dev,
                         s2_reg.target, s2_reg.busy, s2_reg.ready, read_data};
        s2_valid_next = load ? 1'b1 : (move ? 1'b0 : s2_valid_reg);
        if (move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s2_reg <= res_in;
        end
        if (move) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/byte_port_scsi_command_interface.sv @@
// Top level of the byte-port SCSI command interface.
`default_nettype none

// One beat in, one beat out: the block takes a new beat every cycle unless the result
// side stalls or a tag sweep runs, and returns its result through a result stage and an
// output register. The data buffer lives in a single RAM with a registered read port;
// each entry holds a generation tag, so a new command sees an empty buffer without
// clearing it. After reset, and again after every 255 commands that become ready, the
// tags are swept back to zero one entry per cycle; s_tready stays low while the sweep runs.
module byte_port_scsi_command_interface (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // data_byte [7:0], backend_index [23:8]
    input  wire logic [bpsci_pkg::IN_DATA_W-1:0] s_tdata,
    // func [2:0], reg_index [4:3]
    input  wire logic [bpsci_pkg::IN_USER_W-1:0] s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // read_data [7:0], command_ready [8], busy_flag [9], target_device [17:10],
    // to_device [18], cdb_length [26:19], buffer_length [42:27], error_flag [43]
    output logic [bpsci_pkg::OUT_W-1:0]          m_tdata
);

    logic accept;
    logic pipe_ready;
    logic sweep_busy;
    bpsci_pkg::mem_req_t mem_req;
    bpsci_pkg::result_t  res;
    logic [bpsci_pkg::RAM_W-1:0] ram_rdata;

    assign s_tready = pipe_ready && !sweep_busy;
    assign accept   = s_tvalid && s_tready;

    bpsci_cmd u_cmd (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .func          (s_tuser[2:0]),
        .reg_index     (s_tuser[4:3]),
        .data_byte     (s_tdata[7:0]),
        .backend_index (s_tdata[23:8]),
        .mem_req       (mem_req),
        .res           (res),
        .sweep_busy    (sweep_busy)
    );

    bpsci_ram #(
        .WIDTH (bpsci_pkg::RAM_W),
        .DEPTH (bpsci_pkg::BUF_DEPTH)
    ) u_buf_ram (
        .clk   (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.addr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.addr),
        .rdata (ram_rdata)
    );

    bpsci_resp u_resp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .res_in     (res),
        .ram_rdata  (ram_rdata),
        .load_ready (pipe_ready),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

@@ test/byte_port_scsi_command_interface_tb.sv @@
// Self-checking testbench for the byte-port SCSI command interface, with a beat-level scoreboard.
module byte_port_scsi_command_interface_tb;
    import bpsci_pkg::*;

    // Codes that the block must reject.
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;
    localparam logic [1:0] REG_NONE   = 2'd3;

    localparam int RANDOM_BEATS = 1800;
    localparam int TIMEOUT      = 6000000;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        command_ready;
        logic        busy_flag;
        logic [7:0]  target_device;
        logic        to_device;
        logic [7:0]  cdb_length;
        logic [15:0] buffer_length;
        logic        error_flag;
    } port_result_t;

    class port_scoreboard;
        phase_t       ph;
        logic [7:0]   target_id;
        logic [7:0]   dir_byte;
        logic [7:0]   cdb_len;
        logic [7:0]   cdb_fill;
        logic [7:0]   ident;
        logic [7:0]   cdb_mem [CDB_DEPTH];
        logic [15:0]  remaining;
        logic [15:0]  buf_pos;
        logic [7:0]   data_mem [int];
        logic         busy;
        bit           store_live;
        port_result_t pending_results [$];
        int           errors;

        function new();
            clear_command();
            dir_byte   = '0;
            remaining  = '0;
            busy       = 1'b0;
            ident      = '0;
            store_live = 1'b0;
            errors     = 0;
        endfunction

        function void clear_command();
            cdb_len   = '0;
            cdb_fill  = '0;
            buf_pos   = '0;
            target_id = '0;
            ph        = PH_IDLE;
            foreach (cdb_mem[i]) cdb_mem[i] = '0;
        endfunction

        // The buffer reads as empty once a command is ready; returns the pulse.
        function logic command_ready();
            ph = PH_READY;
            data_mem.delete();
            store_live = 1'b1;
            if (dir_byte == 8'd1) return 1'b0;
            busy = 1'b1;
            return 1'b1;
        endfunction

        function logic [7:0] buffer_byte(logic [15:0] pos);
            return data_mem.exists(int'(pos)) ? data_mem[int'(pos)] : 8'd0;
        endfunction

        function void note_beat(logic [2:0] fn, logic [1:0] rg, logic [7:0] val,
                                logic [15:0] bidx);
            port_result_t r;
            logic [7:0]   rd;
            logic         rdy;
            logic         err;
            rd  = '0;
            rdy = 1'b0;
            err = 1'b0;
            case (fn)
                FUNC_BUS_RD: begin
                    if (rg == REG_CMD) begin
                        rd = {7'd0, busy};
                    end else if (rg == REG_DATA) begin
                        if (remaining != 0) begin
                            if (int'(buf_pos) < BUF_DEPTH) rd = buffer_byte(buf_pos);
                            else err = 1'b1;
                            buf_pos   = buf_pos + 16'd1;
                            remaining = remaining - 16'd1;
                            if (remaining == 0) clear_command();
                        end
                    end else if (rg == REG_IDENT) begin
                        rd = ident;
                    end else begin
                        err = 1'b1;
                    end
                end
                FUNC_BUS_WR: begin
                    if (rg == REG_CMD) begin
                        case (ph)
                            PH_IDLE: begin
                                target_id = val;
                                ph = PH_DIR;
                            end
                            PH_DIR: begin
                                dir_byte = val;
                                ph = PH_CDBLEN;
                            end
                            PH_CDBLEN: begin
                                cdb_len = val;
                                if (int'(val) > CDB_DEPTH) err = 1'b1;
                                ph = PH_LENLO;
                            end
                            PH_LENLO: begin
                                remaining = {8'd0, val};
                                ph = PH_LENHI;
                            end
                            PH_LENHI: begin
                                remaining = remaining | {val, 8'd0};
                                if (int'(remaining) > BUF_DEPTH) err = 1'b1;
                                ph = PH_CDB;
                                if (cdb_len == 0) rdy = command_ready();
                            end
                            PH_CDB: begin
                                if (int'(cdb_fill) < CDB_DEPTH) cdb_mem[cdb_fill] = val;
                                else err = 1'b1;
                                cdb_fill = cdb_fill + 8'd1;
                                if (cdb_fill == cdb_len) rdy = command_ready();
                            end
                            default: err = 1'b1;
                        endcase
                    end else if (rg == REG_DATA) begin
                        if (ph == PH_READY && buf_pos < remaining && int'(buf_pos) < BUF_DEPTH)
                        begin
                            data_mem[int'(buf_pos)] = val;
                            buf_pos = buf_pos + 16'd1;
                            if (buf_pos == remaining) begin
                                busy = 1'b1;
                                rdy  = 1'b1;
                            end
                        end else begin
                            err = 1'b1;
                        end
                    end else if (rg == REG_IDENT) begin
                        ident = val;
                    end else begin
                        err = 1'b1;
                    end
                end
                FUNC_BUF_WR, FUNC_BUF_RD: begin
                    if (bidx < remaining && int'(bidx) < BUF_DEPTH) begin
                        if (fn == FUNC_BUF_WR) data_mem[int'(bidx)] = val;
                        else rd = buffer_byte(bidx);
                    end else begin
                        err = 1'b1;
                    end
                end
                FUNC_CDB_RD: begin
                    if (int'(bidx) < int'(cdb_len) && int'(bidx) < CDB_DEPTH) rd = cdb_mem[bidx];
                    else err = 1'b1;
                end
                FUNC_DONE: begin
                    // Completion of a write toward the device also drops the command.
                    if (dir_byte == 8'd1) begin
                        remaining = '0;
                        clear_command();
                    end
                    busy = 1'b0;
                end
                default: err = 1'b1;
            endcase
            r.read_data     = rd;
            r.command_ready = rdy;
            r.busy_flag     = busy;
            r.target_device = target_id;
            r.to_device     = (dir_byte == 8'd1);
            r.cdb_length    = cdb_len;
            r.buffer_length = remaining;
            r.error_flag    = err;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_beat(logic [OUT_W-1:0] d);
            port_result_t e;
            if (pending_results.size() == 0) begin
                $error("result beat %0h arrived with nothing expected", d);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            compare_field("read_data", 16'(e.read_data), 16'(d[7:0]));
            compare_field("command_ready", 16'(e.command_ready), 16'(d[8]));
            compare_field("busy_flag", 16'(e.busy_flag), 16'(d[9]));
            compare_field("target_device", 16'(e.target_device), 16'(d[17:10]));
            compare_field("to_device", 16'(e.to_device), 16'(d[18]));
            compare_field("cdb_length", 16'(e.cdb_length), 16'(d[26:19]));
            compare_field("buffer_length", e.buffer_length, d[42:27]);
            compare_field("error_flag", 16'(e.error_flag), 16'(d[43]));
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [IN_USER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;

    port_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_left;
    int beats_sent;

    byte_port_scsi_command_interface dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #TIMEOUT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random back-pressure, or a long hold-off when one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
    end

    function automatic logic [15:0] any_index();
        return $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 31));
    endfunction

    task automatic send_beat(input logic [2:0] fn, input logic [1:0] rg,
                             input logic [7:0] db, input logic [15:0] bi);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bi, db};
        s_tuser  <= {rg, fn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_beat(fn, rg, db, bi);
        beats_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    // Random beat that cannot derail a command in flight: no header writes, no data reads
    // while bytes remain, no completion that would drop an outgoing command.
    task automatic noise_beat();
        logic [2:0] fn;
        logic [1:0] rg;
        fn = 3'($urandom_range(7));
        rg = 2'($urandom_range(3));
        if (fn == FUNC_BUS_WR && rg == REG_CMD) rg = REG_IDENT;
        if (fn == FUNC_BUS_RD && rg == REG_DATA && sb.remaining != 0) rg = REG_IDENT;
        if (fn == FUNC_DONE && sb.dir_byte == 8'd1 && sb.ph != PH_IDLE) fn = FUNC_CDB_RD;
        if (fn == FUNC_BUF_RD && !sb.store_live) fn = FUNC_CDB_RD;
        send_beat(fn, rg, 8'($urandom), any_index());
    endtask

    // Backend access, mostly around the valid window so both edges of it are hit.
    task automatic backend_beat();
        logic [2:0]  fn;
        logic [15:0] idx;
        case ($urandom_range(2))
            0: fn = FUNC_BUF_WR;
            1: fn = FUNC_BUF_RD;
            default: fn = FUNC_CDB_RD;
        endcase
        if ($urandom_range(4) == 0) idx = 16'($urandom);
        else if (fn == FUNC_CDB_RD) idx = 16'($urandom_range(0, int'(sb.cdb_len) + 1));
        else idx = 16'($urandom_range(0, int'(sb.remaining)));
        send_beat(fn, REG_CMD, 8'($urandom), idx);
    endtask

    task automatic run_command(input bit to_dev, input logic [7:0] cdb_n,
                               input logic [15:0] len);
        logic [7:0] dir_val;
        int         n;
        if (to_dev) dir_val = 8'd1;
        else dir_val = $urandom_range(1) ? 8'($urandom_range(2, 255)) : 8'd0;
        send_beat(FUNC_BUS_WR, REG_CMD, 8'($urandom), any_index());
        send_beat(FUNC_BUS_WR, REG_CMD, dir_val, any_index());
        send_beat(FUNC_BUS_WR, REG_CMD, cdb_n, any_index());
        send_beat(FUNC_BUS_WR, REG_CMD, len[7:0], any_index());
        send_beat(FUNC_BUS_WR, REG_CMD, len[15:8], any_index());
        while (sb.ph == PH_CDB) begin
            if ($urandom_range(9) == 0) noise_beat();
            send_beat(FUNC_BUS_WR, REG_CMD, 8'($urandom), any_index());
        end
        if (sb.ph != PH_READY) return;
        // A header write while the command is ready must be refused.
        if ($urandom_range(7) == 0) send_beat(FUNC_BUS_WR, REG_CMD, 8'($urandom), any_index());
        if (to_dev) begin
            n = (len > 16'd32) ? $urandom_range(1, 6) : int'(len);
            repeat (n) begin
                if ($urandom_range(4) == 0) backend_beat();
                send_beat(FUNC_BUS_WR, REG_DATA, 8'($urandom), any_index());
            end
            if ($urandom_range(3) == 0) send_beat(FUNC_BUS_WR, REG_DATA, 8'($urandom), 16'd0);
            repeat ($urandom_range(1, 4)) backend_beat();
            send_beat(FUNC_BUS_RD, REG_CMD, 8'($urandom), any_index());
            send_beat(FUNC_DONE, REG_CMD, 8'($urandom), any_index());
        end else begin
            repeat ($urandom_range(0, int'(len) + 2)) backend_beat();
            send_beat(FUNC_DONE, REG_CMD, 8'($urandom), any_index());
            send_beat(FUNC_BUS_RD, REG_CMD, 8'($urandom), any_index());
            while (sb.remaining != 0) begin
                if ($urandom_range(5) == 0) noise_beat();
                send_beat(FUNC_BUS_RD, REG_DATA, 8'($urandom), any_index());
            end
            if ($urandom_range(3) == 0) send_beat(FUNC_BUS_RD, REG_DATA, 8'($urandom), 16'd0);
        end
    endtask

    task automatic random_command();
        bit          to_dev;
        int          r;
        logic [7:0]  cdb_n;
        logic [15:0] len;
        to_dev = $urandom_range(1);
        r = $urandom_range(99);
        if (r < 10) cdb_n = 8'd0;
        else if (r < 80) cdb_n = 8'($urandom_range(1, 12));
        else if (r < 90) cdb_n = 8'(CDB_DEPTH);
        else cdb_n = 8'($urandom_range(CDB_DEPTH + 1, CDB_DEPTH + 4));
        // Long buffers only toward the device, where completion can cut them short.
        if (to_dev) len = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
        else len = 16'($urandom_range(1, 16));
        run_command(to_dev, cdb_n, len);
    endtask

    initial begin
        int goal;
        sb         = new();
        idle_pct   = 0;
        stall_pct  = 0;
        hold_left  = 0;
        beats_sent = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register corners, rejected codes and accesses with no command set up.
        send_beat(FUNC_BUS_RD, REG_CMD, 8'h00, 16'h0000);
        send_beat(FUNC_BUS_RD, REG_IDENT, 8'h00, 16'h0000);
        send_beat(FUNC_BUS_WR, REG_IDENT, 8'hFF, 16'hFFFF);
        send_beat(FUNC_BUS_RD, REG_IDENT, 8'hFF, 16'hFFFF);
        send_beat(FUNC_BUS_WR, REG_IDENT, 8'h00, 16'h0000);
        send_beat(FUNC_BUS_WR, REG_NONE, 8'hFF, 16'h0000);
        send_beat(FUNC_BUS_RD, REG_NONE, 8'h00, 16'hFFFF);
        send_beat(FUNC_RSVD6, REG_CMD, 8'h5A, 16'h0001);
        send_beat(FUNC_RSVD7, REG_NONE, 8'hFF, 16'hFFFF);
        send_beat(FUNC_CDB_RD, REG_CMD, 8'h00, 16'h0000);
        send_beat(FUNC_BUF_WR, REG_CMD, 8'hA5, 16'h0000);
        send_beat(FUNC_BUS_WR, REG_DATA, 8'h3C, 16'h0000);
        send_beat(FUNC_BUS_RD, REG_DATA, 8'h00, 16'h0000);
        // Zero CDB length: ready straight from the high length byte.
        run_command(1'b0, 8'd0, 16'd2);
        wait_for_results();

        goal = beats_sent;
        for (int ph_i = 0; ph_i < 4; ph_i++) begin
            case (ph_i)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            // Fill the block against a stopped result side.
            if (ph_i == 2) hold_left = 200;
            // Longest header and buffer fields, then cut short by completion.
            if (ph_i == 3) run_command(1'b1, 8'hFF, 16'hFFFF);
            goal += RANDOM_BEATS / 4;
            while (beats_sent < goal) begin
                repeat ($urandom_range(0, 2)) noise_beat();
                random_command();
            end
            wait_for_results();
        end

        // A zero-length read from the device leaves the command stuck in the ready state.
        run_command(1'b0, 8'd3, 16'd0);
        send_beat(FUNC_BUS_WR, REG_CMD, 8'h11, 16'h0000);
        send_beat(FUNC_DONE, REG_CMD, 8'h00, 16'h0000);
        repeat (6) noise_beat();

        wait_for_results();
        repeat (16) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

@@ byte_port_scsi_command_interface.f @@
rtl/core/bpsci_pkg.sv
rtl/core/bpsci_ram.sv
rtl/core/bpsci_cmd.sv
rtl/core/bpsci_resp.sv
rtl/core/byte_port_scsi_command_interface.sv
test/byte_port_scsi_command_interface_tb.sv
